[hdl/bmgc_pkg.sv]
// Shared types and constants for the button mode and gun calibration block.
package bmgc_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_PRE    = 2'd1,
    MODE_CONFIG = 2'd2,
    MODE_ADJUST = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_GO,
    ST_WAIT,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic {
    AR_IDLE,
    AR_RUN
  } arith_state_e;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_e;

  typedef enum logic [1:0] {
    CFG_CONFIG_HOLD = 2'd0,
    CFG_ADJUST_HOLD = 2'd1,
    CFG_WIDTH       = 2'd2,
    CFG_HEIGHT      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  typedef struct packed {
    logic [9:0] mapped_y;
    logic [9:0] mapped_x;
    logic       normal_service;
    logic       normal_test;
    logic       save_request;
    logic       setting_changed;
    logic [2:0] setting_index;
    mode_e      mode;
  } res_t;

  localparam int unsigned ArithSteps = 16;
  localparam int unsigned StepW      = $clog2(ArithSteps);
  localparam int unsigned NumProfiles = 6;
  localparam int unsigned AdjSamples  = 4;

  localparam logic [7:0]  ConfigHoldRst = 8'd60;
  localparam logic [7:0]  AdjustHoldRst = 8'd180;
  localparam logic [10:0] WidthRst      = 11'd640;
  localparam logic [10:0] HeightRst     = 11'd960;
  localparam logic [15:0] ScaleRst      = 16'h0400;
  localparam logic [15:0] WordMax       = 16'hffff;
  localparam logic [7:0]  CntConfigIdle = 8'd3;
  localparam logic [9:0]  MapMax        = 10'h3ff;

endpackage

[hdl/bmgc_alu.sv]
// Shared 32-bit add/subtract unit with carry out (borrow on subtract).
module bmgc_alu (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sub_i,
  output logic [32:0] sum_o
);

  always_comb begin
    if (sub_i) begin
      sum_o = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      sum_o = {1'b0, a_i} + {1'b0, b_i};
    end
  end

endmodule

[hdl/bmgc_arith.sv]
// Sequencer for 16-step shift-add multiply and restoring divide on the shared ALU.
module bmgc_arith
  import bmgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  arith_req_t  req_i,
  input  logic [15:0] opa_i,
  input  logic [15:0] opb_i,
  output arith_rsp_t  rsp_o,
  output logic [31:0] result_o
);

  arith_state_e     state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [31:0]      acc_q, acc_d;
  logic [15:0]      sh_q, sh_d;
  logic [15:0]      opb_q, opb_d;
  arith_op_e        op_q, op_d;

  logic [31:0] alu_a, alu_b;
  logic        alu_sub;
  logic [32:0] alu_sum;
  logic        qbit;
  logic        last;

  bmgc_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign last = (cnt_q == StepW'(ArithSteps - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AR_IDLE: if (req_i.start) state_d = AR_RUN;
      AR_RUN:  if (last) state_d = AR_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.busy = (state_q == AR_RUN);
    rsp_o.done = done_q;
    result_o   = (op_q == OP_MUL) ? acc_q : {16'b0, sh_q};
  end

  always_comb begin
    if (op_q == OP_MUL) begin
      alu_a   = {acc_q[30:0], 1'b0};
      alu_b   = sh_q[15] ? {16'b0, opb_q} : 32'b0;
      alu_sub = 1'b0;
    end else begin
      alu_a   = {15'b0, acc_q[15:0], 1'b0};
      alu_b   = {16'b0, opb_q};
      alu_sub = 1'b1;
    end
  end

  always_comb begin
    qbit = ~alu_sum[32];

    acc_d  = acc_q;
    sh_d   = sh_q;
    opb_d  = opb_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (state_q == AR_IDLE) begin
      if (req_i.start) begin
        op_d  = req_i.op;
        opb_d = opb_i;
        cnt_d = '0;
        acc_d = (req_i.op == OP_DIV) ? {16'b0, opa_i} : 32'b0;
        sh_d  = (req_i.op == OP_MUL) ? opa_i : 16'b0;
      end
    end else begin
      cnt_d  = cnt_q + StepW'(1);
      done_d = last;
      if (op_q == OP_MUL) begin
        acc_d = alu_sum[31:0];
        sh_d  = {sh_q[14:0], 1'b0};
      end else begin
        acc_d = qbit ? {16'b0, alu_sum[15:0]} : {16'b0, alu_a[15:0]};
        sh_d  = {sh_q[14:0], qbit};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    opb_q <= opb_d;
    op_q  <= op_d;
  end

endmodule

[hdl/button_mode_and_gun_calibration_top.sv]
// Top level: mode controller for a two-button board with light-gun calibration.
//
// Input stream (s_axis_*): one item per transfer; tuser is the command
// (0 poll tick, 1 map a coordinate pair), tdata carries buttons, trigger
// bytes and the gun x/y. Output stream (m_axis_*): exactly one result per
// item, in order. Config channel (cfg_*): register index and data, always
// ready; write it only while the block is idle.
// A map item, or the tick that completes calibration, runs up to two 16-step
// passes of the shared add/subtract unit (shift-add multiply or restoring
// divide, one per axis); an axis that needs no pass (below base, zero size,
// saturated scale) skips it. Flow: one item at a time; s_axis_tready is
// high only while the sequencer is idle, so a new item is taken only once
// the result of the last one has gone into the output register.
// The output register holds a finished result while the receiver stalls;
// the next item is still taken, but its result waits until the output
// register frees up.
// Reset: normal mode, counters and profile cleared, base words 0, scale
// words 0x0400, registers back to 60/180/640/960.
module button_mode_and_gun_calibration_top
  import bmgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // service_button, test_button, trigger_low_bits[7:0], trigger_byte[7:0],
  // raw_x[15:0], raw_y[15:0], zero pad
  input  logic [55:0] s_axis_tdata,
  // command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mode[1:0], setting_index[2:0], setting_changed, save_request,
  // normal_test, normal_service, mapped_x[9:0], mapped_y[9:0], zero pad
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  ctrl_state_e state_q, state_d;

  logic [7:0]  cfg_hold_q, adj_hold_q;
  logic [10:0] width_q, height_q;

  mode_e       mode_q;
  logic [7:0]  cnt_q;
  logic [2:0]  prof_q;
  logic [15:0] w_q [4];

  logic        cmd_q, svc_q, tst_q, trig_q;
  logic [15:0] x_q, y_q;

  logic        ax_q;
  arith_op_e   op_q;
  res_t        res_q, out_q;
  logic        out_valid_q;

  // tick logic
  mode_e      mode_n;
  logic [7:0] cnt_n, hold_inc, adj_s;
  logic [2:0] prof_n;
  logic [3:0] prof_inc, adj_hi;
  logic       chg, save, adj_enter, take_pt, calib_done;

  // per-axis logic
  logic [10:0] size_ax, size_m1;
  logic [15:0] base_ax, top_ax, v_ax, span, diff, div_val;
  logic [9:0]  limit, map_val;
  logic        div_skip, map_skip, skip, is_div, over;

  arith_req_t  arith_req;
  arith_rsp_t  arith_rsp;
  logic [15:0] arith_opa, arith_opb;
  logic [31:0] arith_res;

  logic accept, out_free, load_out, axis_wr, tick_en;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_n     = mode_q;
    cnt_n      = cnt_q;
    prof_n     = prof_q;
    chg        = 1'b0;
    save       = 1'b0;
    adj_enter  = 1'b0;
    take_pt    = 1'b0;
    calib_done = 1'b0;
    hold_inc   = cnt_q + 8'd1;
    prof_inc   = {1'b0, prof_q} + 4'd1;
    adj_s      = {cnt_q[7:4], cnt_q[2:0], trig_q};
    adj_hi     = cnt_q[7:4] + 4'd1;
    if (!cmd_q) begin
      unique case (mode_q)
        MODE_NORMAL: begin
          if (svc_q && tst_q) begin
            cnt_n = hold_inc;
            if (hold_inc >= cfg_hold_q) mode_n = MODE_PRE;
          end else begin
            cnt_n = 8'd0;
          end
        end
        MODE_PRE: begin
          if (svc_q && tst_q) begin
            cnt_n = hold_inc;
            if (hold_inc >= adj_hold_q) begin
              mode_n    = MODE_ADJUST;
              cnt_n     = 8'd0;
              adj_enter = 1'b1;
            end
          end else begin
            cnt_n  = CntConfigIdle;
            mode_n = MODE_CONFIG;
          end
        end
        MODE_CONFIG: begin
          if (!cnt_q[1] && svc_q) begin
            mode_n = MODE_NORMAL;
            save   = 1'b1;
          end else if (!cnt_q[0] && tst_q) begin
            prof_n = (prof_inc >= 4'(NumProfiles)) ? 3'd0 : prof_inc[2:0];
            chg    = 1'b1;
          end
          cnt_n = {6'b0, svc_q, tst_q};
        end
        MODE_ADJUST: begin
          cnt_n = adj_s;
          if (adj_s[3:0] == 4'b0001) begin
            take_pt = 1'b1;
            cnt_n   = {adj_hi, adj_s[3:0]};
            if (adj_hi >= 4'(AdjSamples)) begin
              mode_n     = MODE_NORMAL;
              cnt_n      = 8'd0;
              save       = 1'b1;
              calib_done = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    size_ax  = ax_q ? height_q : width_q;
    base_ax  = ax_q ? w_q[1] : w_q[0];
    top_ax   = ax_q ? w_q[3] : w_q[2];
    v_ax     = ax_q ? y_q : x_q;
    is_div   = (op_q == OP_DIV);
    span     = top_ax - base_ax;
    div_skip = (top_ax < base_ax) || (span == 16'd0) || ({5'b0, size_ax} >= span);
    div_val  = div_skip ? WordMax : arith_res[15:0];
    map_skip = (size_ax == 11'd0) || (v_ax < base_ax);
    diff     = v_ax - base_ax;
    size_m1  = size_ax - 11'd1;
    limit    = (size_m1 > {1'b0, MapMax}) ? MapMax : size_m1[9:0];
    over     = arith_res > {6'b0, limit, 16'b0};
    if (map_skip) begin
      map_val = 10'd0;
    end else if (over) begin
      map_val = limit;
    end else begin
      map_val = arith_res[25:16];
    end
    skip      = is_div ? div_skip : map_skip;
    arith_opa = is_div ? {5'b0, size_ax} : diff;
    arith_opb = is_div ? span : top_ax;
  end

  bmgc_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (arith_req),
    .opa_i    (arith_opa),
    .opb_i    (arith_opb),
    .rsp_o    (arith_rsp),
    .result_o (arith_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_TICK;
      ST_TICK: state_d = (cmd_q || calib_done) ? ST_GO : ST_EMIT;
      ST_GO: begin
        if (skip) state_d = ax_q ? ST_EMIT : ST_GO;
        else      state_d = ST_WAIT;
      end
      ST_WAIT: if (arith_rsp.done) state_d = ax_q ? ST_EMIT : ST_GO;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready   = (state_q == ST_IDLE);
    tick_en         = (state_q == ST_TICK);
    arith_req.start = (state_q == ST_GO) && !skip;
    arith_req.op    = op_q;
    axis_wr         = ((state_q == ST_GO) && skip) ||
                      ((state_q == ST_WAIT) && arith_rsp.done);
    load_out        = (state_q == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_hold_q  <= ConfigHoldRst;
      adj_hold_q  <= AdjustHoldRst;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
      mode_q      <= MODE_NORMAL;
      cnt_q       <= 8'd0;
      prof_q      <= 3'd0;
      w_q[0]      <= 16'd0;
      w_q[1]      <= 16'd0;
      w_q[2]      <= ScaleRst;
      w_q[3]      <= ScaleRst;
      ax_q        <= 1'b0;
      op_q        <= OP_MUL;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_CONFIG_HOLD: cfg_hold_q <= cfg_data_i[7:0];
          CFG_ADJUST_HOLD: adj_hold_q <= cfg_data_i[7:0];
          CFG_WIDTH:       width_q    <= cfg_data_i;
          CFG_HEIGHT:      height_q   <= cfg_data_i;
        endcase
      end
      if (tick_en) begin
        mode_q <= mode_n;
        cnt_q  <= cnt_n;
        prof_q <= prof_n;
        ax_q   <= 1'b0;
        op_q   <= cmd_q ? OP_MUL : OP_DIV;
        if (adj_enter) begin
          w_q[0] <= WordMax;
          w_q[1] <= WordMax;
          w_q[2] <= 16'd0;
          w_q[3] <= 16'd0;
        end else if (take_pt) begin
          if (x_q < w_q[0]) w_q[0] <= x_q;
          if (y_q < w_q[1]) w_q[1] <= y_q;
          if (w_q[2] < x_q) w_q[2] <= x_q;
          if (w_q[3] < y_q) w_q[3] <= y_q;
        end
      end
      if (axis_wr) begin
        ax_q <= 1'b1;
        if (is_div) begin
          if (ax_q) w_q[3] <= div_val;
          else      w_q[2] <= div_val;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser;
      svc_q  <= s_axis_tdata[0];
      tst_q  <= s_axis_tdata[1];
      trig_q <= (s_axis_tdata[3:2] != 2'b0) || (s_axis_tdata[17:10] != 8'd0);
      x_q    <= s_axis_tdata[33:18];
      y_q    <= s_axis_tdata[49:34];
    end
    if (tick_en) begin
      res_q.mode            <= mode_n;
      res_q.setting_index   <= prof_n;
      res_q.setting_changed <= chg;
      res_q.save_request    <= save;
      res_q.normal_test     <= (mode_n == MODE_NORMAL) && tst_q;
      res_q.normal_service  <= (mode_n == MODE_NORMAL) && svc_q;
      res_q.mapped_x        <= 10'd0;
      res_q.mapped_y        <= 10'd0;
    end
    if (axis_wr && !is_div) begin
      if (ax_q) res_q.mapped_y <= map_val;
      else      res_q.mapped_x <= map_val;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_q.mapped_y, out_q.mapped_x, out_q.normal_service,
                          out_q.normal_test, out_q.save_request, out_q.setting_changed,
                          out_q.setting_index, out_q.mode};

  a_ready_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !arith_rsp.busy)
    else $error("input ready while arithmetic unit busy");

  a_prof_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, prof_q} < 4'(NumProfiles))
    else $error("profile index out of range");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_rsp.done |-> (state_q == ST_WAIT))
    else $error("arithmetic done outside wait state");

  a_config_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_CONFIG) |-> (cnt_q[7:2] == 6'd0))
    else $error("config mode button history corrupted");

endmodule
